// File: rtl/core/gf16_region_multiply_accumulate_core_macros.svh
// Assertion macros for the GF(2^16) region multiply-accumulate core.
// No dependencies; taken by `include in the files that check their logic.
`ifndef GF16_REGION_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH
`define GF16_REGION_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define GFRMAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfrmac: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define GFRMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfrmac: next-cycle check failed");

`else

`define GFRMAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define GFRMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/gfrmac_pkg.sv
// Shared constants and types for the GF(2^16) region multiply-accumulate core.
// No dependencies.
`timescale 1ns / 1ps

package gfrmac_pkg;

  localparam int GF_BITS         = 16;
  localparam int MAX_LANES       = 4;
  localparam int LANES           = 4;
  localparam int STEPS_PER_STAGE = 4;
  localparam int STAGES          = GF_BITS / STEPS_PER_STAGE;

  // x^16 + x^12 + x^3 + x + 1 with the x^16 term dropped
  localparam logic [GF_BITS-1:0] GF_POLY_LOW = 16'h100B;

  typedef logic [GF_BITS-1:0] gf_word_t;

  // a: source word times x^step, prod: destination word plus partial product
  typedef struct packed {
    gf_word_t [MAX_LANES-1:0] a;
    gf_word_t [MAX_LANES-1:0] prod;
    logic                     last;
  } gfrmac_data_t;

endpackage

// File: rtl/core/gfrmac_stage.sv
// One pipeline stage of the GF(2^16) multiply-accumulate: four shift-and-add steps.
// Depends on gfrmac_pkg.
`timescale 1ns / 1ps

module gfrmac_stage import gfrmac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  gfrmac_data_t               up_data,
  input  logic [STEPS_PER_STAGE-1:0] fac_bits,
  input  logic                       dn_ready,
  output logic                       up_ready,
  output logic                       valid_r,
  output gfrmac_data_t               data_r
);

  gfrmac_data_t data_nxt;

  always_comb begin
    logic     carry;
    gf_word_t a_w;
    gf_word_t p_w;
    data_nxt      = up_data;
    for (int k = 0; k < MAX_LANES; k++) begin
      a_w = up_data.a[k];
      p_w = up_data.prod[k];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (fac_bits[j]) begin
          p_w = p_w ^ a_w;
        end
        carry = a_w[GF_BITS-1];
        a_w   = {a_w[GF_BITS-2:0], 1'b0} ^ (carry ? GF_POLY_LOW : '0);
      end
      data_nxt.a[k]    = a_w;
      data_nxt.prod[k] = p_w;
    end
  end

  // advance when the next stage takes our request or we hold nothing
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/core/gf16_region_multiply_accumulate_core.sv
// Top level of the GF(2^16) region multiply-accumulate core (poly 0x1100B).
// Depends on gfrmac_pkg, gfrmac_stage and the assertion macro header.
`timescale 1ns / 1ps
`include "gf16_region_multiply_accumulate_core_macros.svh"

// Each request carries four source and four destination words; the result gives
// dst XOR (src * factor) in GF(2^16) for every lane, with the last marker copied.
// Throughput is one request per cycle while out_stall is low. A request passes
// through the four register stages, of four shift-and-add steps each, before
// it reaches out_valid. The factor comes from cfg_wr_data and must be written
// only while the pipeline is empty. in_stall rises only when every stage holds
// a request and the output is stalled.

module gf16_region_multiply_accumulate_core import gfrmac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  gf_word_t cfg_wr_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  gf_word_t in_src_word0,
  input  gf_word_t in_src_word1,
  input  gf_word_t in_src_word2,
  input  gf_word_t in_src_word3,
  input  gf_word_t in_dst_word0,
  input  gf_word_t in_dst_word1,
  input  gf_word_t in_dst_word2,
  input  gf_word_t in_dst_word3,
  input  logic     in_last_in,
  output logic     out_valid,
  input  logic     out_stall,
  output gf_word_t out_word0,
  output gf_word_t out_word1,
  output gf_word_t out_word2,
  output gf_word_t out_word3,
  output logic     out_last_out
);

  gf_word_t factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= '0;
    end else if (cfg_wr_en) begin
      factor_r <= cfg_wr_data;
    end
  end

  gf_word_t [MAX_LANES-1:0] src_w;
  gf_word_t [MAX_LANES-1:0] dst_w;
  gfrmac_data_t             in_data;

  assign src_w = {in_src_word3, in_src_word2, in_src_word1, in_src_word0};
  assign dst_w = {in_dst_word3, in_dst_word2, in_dst_word1, in_dst_word0};

  // unused lanes enter as zero and stay zero
  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_used
      assign in_data.a[k]    = src_w[k];
      assign in_data.prod[k] = dst_w[k];
    end else begin : g_unused
      assign in_data.a[k]    = '0;
      assign in_data.prod[k] = '0;
    end
  end
  assign in_data.last = in_last_in;

  logic         stage_valid [STAGES];
  gfrmac_data_t stage_data  [STAGES];
  logic         stage_ready [STAGES+1];

  assign stage_ready[STAGES] = !out_stall;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic         up_valid_w;
    gfrmac_data_t up_data_w;

    if (s == 0) begin : g_first
      assign up_valid_w = in_valid;
      assign up_data_w  = in_data;
    end else begin : g_rest
      assign up_valid_w = stage_valid[s-1];
      assign up_data_w  = stage_data[s-1];
    end

    gfrmac_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (up_valid_w),
      .up_data  (up_data_w),
      .fac_bits (factor_r[s*STEPS_PER_STAGE +: STEPS_PER_STAGE]),
      .dn_ready (stage_ready[s+1]),
      .up_ready (stage_ready[s]),
      .valid_r  (stage_valid[s]),
      .data_r   (stage_data[s])
    );
  end

  assign in_stall     = !stage_ready[0];
  assign out_valid    = stage_valid[STAGES-1];
  assign out_word0    = stage_data[STAGES-1].prod[0];
  assign out_word1    = stage_data[STAGES-1].prod[1];
  assign out_word2    = stage_data[STAGES-1].prod[2];
  assign out_word3    = stage_data[STAGES-1].prod[3];
  assign out_last_out = stage_data[STAGES-1].last;

  `GFRMAC_ASSERT_NEXT(a_accept_loads_first, clk, rst_n, in_valid && !in_stall, stage_valid[0])
  `GFRMAC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, stage_valid[0] && stage_valid[1] && stage_valid[2] && stage_valid[3] && out_stall)
  `GFRMAC_ASSERT_NEXT(a_mid_stage_holds, clk, rst_n, stage_valid[1] && !stage_ready[2], stage_valid[1])

endmodule
